// ----- hdl/nx256_pkg.sv -----
// ----------------------------------------------------------------------------
// nx256_pkg
// Shared types, constants and palette helpers for the xterm-256 color matcher.
// ----------------------------------------------------------------------------
package nx256_pkg;

    localparam int CH_W       = 8;
    localparam int CODE_W     = 8;
    localparam int THR_W      = 9;
    localparam int SQ_W       = 2 * CH_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int DIGIT_W    = 3;

    localparam logic [CODE_W-1:0]  PAL_FIRST_CODE   = 8'd16;
    localparam logic [CODE_W-1:0]  PAL_LAST_CODE    = 8'd255;
    localparam logic [CODE_W-1:0]  TRANSPARENT_CODE = 8'd1;
    localparam logic [THR_W-1:0]   THR_RESET        = 9'd128;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 3'd5;
    localparam logic [CH_W-1:0]    GRAY_FIRST       = 8'd8;
    localparam logic [CH_W-1:0]    GRAY_STEP        = 8'd10;

    // controller to datapath
    typedef struct packed {
        logic start;   // capture pixel, restart the palette walk
        logic issue;   // walk may advance this cycle
    } nx256_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              search_done;  // last entry is compared at this edge
        logic [CODE_W-1:0] best_code;
    } nx256_status_t;

    // channel level of one 6x6x6 cube digit
    function automatic logic [CH_W-1:0] cube_level(input logic [DIGIT_W-1:0] digit);
        logic [CH_W-1:0] lvl;
        case (digit)
            3'd0:    lvl = 8'h00;
            3'd1:    lvl = 8'h5f;
            3'd2:    lvl = 8'h87;
            3'd3:    lvl = 8'haf;
            3'd4:    lvl = 8'hd7;
            3'd5:    lvl = 8'hff;
            default: lvl = 8'h00;
        endcase
        return lvl;
    endfunction

endpackage

// ----- hdl/nx256_dpath.sv -----
// ----------------------------------------------------------------------------
// nx256_dpath
// Palette walk, squared RGB distance pipeline and best-match tracking.
// ----------------------------------------------------------------------------
module nx256_dpath import nx256_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  nx256_cmd_t        cmd,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    output nx256_status_t     status
);

    // pixel capture
    logic [CH_W-1:0] pix_r_reg, pix_g_reg, pix_b_reg;

    // palette walk counters
    logic               busy_reg, busy_next;
    logic               gray_reg, gray_next;
    logic [DIGIT_W-1:0] dr_reg, dr_next, dg_reg, dg_next, db_reg, db_next;
    logic [CH_W-1:0]    glvl_reg, glvl_next;
    logic [CODE_W-1:0]  gidx_reg, gidx_next;

    // pipeline stages
    logic              v0_reg, v1_reg, v2_reg;
    logic [CODE_W-1:0] idx0_reg, idx1_reg, idx2_reg;
    logic [CH_W-1:0]   e_r_reg, e_g_reg, e_b_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0] dist_reg;

    // best match
    logic [DIST_W-1:0] best_dist_reg;
    logic [CODE_W-1:0] best_code_reg;

    logic              advance;
    logic [CH_W-1:0]   ent_r, ent_g, ent_b;
    logic [CH_W-1:0]   ad_r, ad_g, ad_b;

    assign advance = cmd.issue && busy_reg;

    // current entry color
    always_comb begin
        if (gray_reg) begin
            ent_r = glvl_reg;
            ent_g = glvl_reg;
            ent_b = glvl_reg;
        end else begin
            ent_r = cube_level(dr_reg);
            ent_g = cube_level(dg_reg);
            ent_b = cube_level(db_reg);
        end
    end

    // next walk position: cube digits, then gray ramp
    always_comb begin
        busy_next = busy_reg;
        gray_next = gray_reg;
        dr_next   = dr_reg;
        dg_next   = dg_reg;
        db_next   = db_reg;
        glvl_next = glvl_reg;
        gidx_next = gidx_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            gray_next = 1'b0;
            dr_next   = '0;
            dg_next   = '0;
            db_next   = '0;
            glvl_next = GRAY_FIRST;
            gidx_next = PAL_FIRST_CODE;
        end else if (advance) begin
            gidx_next = gidx_reg + 8'd1;
            if (gidx_reg == PAL_LAST_CODE) begin
                busy_next = 1'b0;
            end
            if (gray_reg) begin
                glvl_next = glvl_reg + GRAY_STEP;
            end else if (db_reg != DIGIT_MAX) begin
                db_next = db_reg + 3'd1;
            end else begin
                db_next = '0;
                if (dg_reg != DIGIT_MAX) begin
                    dg_next = dg_reg + 3'd1;
                end else begin
                    dg_next = '0;
                    if (dr_reg != DIGIT_MAX) begin
                        dr_next = dr_reg + 3'd1;
                    end else begin
                        gray_next = 1'b1;
                    end
                end
            end
        end
    end

    // absolute channel differences
    always_comb begin
        ad_r = (e_r_reg > pix_r_reg) ? (e_r_reg - pix_r_reg) : (pix_r_reg - e_r_reg);
        ad_g = (e_g_reg > pix_g_reg) ? (e_g_reg - pix_g_reg) : (pix_g_reg - e_g_reg);
        ad_b = (e_b_reg > pix_b_reg) ? (e_b_reg - pix_b_reg) : (pix_b_reg - e_b_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            v0_reg   <= advance;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
        end
    end

    // walk counters, pipeline payload and best match
    always_ff @(posedge aclk) begin
        gray_reg <= gray_next;
        dr_reg   <= dr_next;
        dg_reg   <= dg_next;
        db_reg   <= db_next;
        glvl_reg <= glvl_next;
        gidx_reg <= gidx_next;
        if (cmd.start) begin
            pix_r_reg <= red;
            pix_g_reg <= green;
            pix_b_reg <= blue;
        end
        // stage 0: entry color
        e_r_reg  <= ent_r;
        e_g_reg  <= ent_g;
        e_b_reg  <= ent_b;
        idx0_reg <= gidx_reg;
        // stage 1: squares
        sq_r_reg <= ad_r * ad_r;
        sq_g_reg <= ad_g * ad_g;
        sq_b_reg <= ad_b * ad_b;
        idx1_reg <= idx0_reg;
        // stage 2: sum
        dist_reg <= {2'b00, sq_r_reg} + {2'b00, sq_g_reg} + {2'b00, sq_b_reg};
        idx2_reg <= idx1_reg;
        // compare, lower index kept on a tie
        if (v2_reg && ((idx2_reg == PAL_FIRST_CODE) || (dist_reg < best_dist_reg))) begin
            best_dist_reg <= dist_reg;
            best_code_reg <= idx2_reg;
        end
    end

    assign status.search_done = v2_reg && (idx2_reg == PAL_LAST_CODE);
    assign status.best_code   = best_code_reg;

endmodule

// ----- hdl/nx256_ctrl.sv -----
// ----------------------------------------------------------------------------
// nx256_ctrl
// Request sequencing, alpha test, threshold register and result register.
// ----------------------------------------------------------------------------
module nx256_ctrl import nx256_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [THR_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CH_W-1:0]   alpha,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CODE_W-1:0] m_code,
    output nx256_cmd_t        cmd,
    input  nx256_status_t     status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic              trans_reg;
    logic              m_valid_reg;
    logic [CODE_W-1:0] m_code_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              accept;
    logic              out_free;
    logic              is_trans;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign is_trans  = {1'b0, alpha} < thr_reg;
    assign cmd.start = accept;
    assign cmd.issue = (state_reg == ST_SEARCH);
    assign m_tvalid  = m_valid_reg;
    assign m_code    = m_code_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            trans_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // result valid: set on completion, cleared once taken
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        trans_reg <= is_trans;
                        state_reg <= is_trans ? ST_DONE : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (status.search_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_code_reg  <= trans_reg ? TRANSPARENT_CODE : status.best_code;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/nearest_xterm256_color_rgb.sv -----
// ----------------------------------------------------------------------------
// nearest_xterm256_color_rgb
// Maps an RGBA pixel to the nearest xterm-256 palette index, or to the
// transparent code when alpha is below the programmed threshold.
// ----------------------------------------------------------------------------
// an opaque pixel is compared with the palette before its result is registered; a
//   transparent one is not; a new request waits until the last result is registered
// the one distance pipeline walks palette entries 16..255, one per cycle
// reset (aresetn low, synchronous) empties the pipeline and the result
//   register and sets the alpha threshold to 128
// ----------------------------------------------------------------------------
module nearest_xterm256_color_rgb import nx256_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data,   // alpha_threshold
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,       // red, green, blue, alpha
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata        // color_code
);

    nx256_cmd_t    cmd;
    nx256_status_t status;

    nx256_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .alpha       (s_tdata[31:24]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_code      (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

    nx256_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .red     (s_tdata[7:0]),
        .green   (s_tdata[15:8]),
        .blue    (s_tdata[23:16]),
        .status  (status)
    );

endmodule
